>>> rtl/assert_macros.svh
// Assertion macros for RTL files that carry concurrent checks; used by scanline_dark_run_classifier_top.
// Depends on nothing; each macro expands to one labelled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SDRC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset
`define SDRC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

>>> rtl/sdrc_pkg.sv
// Types and constants of the scanline dark run classifier.
// No dependencies; imported by every module of the block.
package sdrc_pkg;

   // field widths
   localparam int PIX_W      = 8;
   localparam int ROW_W      = 11;
   localparam int THR_W      = 16;
   localparam int CLASS_W    = 2;
   localparam int MID_W      = 12;
   localparam int RUN_W      = 12;
   localparam int SUM_W      = 20;
   localparam int CSR_W      = 8;
   localparam int Q_W        = 16;
   localparam int ROW_TERM_W = 18;

   // beat layouts
   localparam int REQ_DATA_W = 40;
   localparam int REQ_USER_W = 1;
   localparam int RSP_DATA_W = 32;
   localparam int RSP_PAD_W  = RSP_DATA_W - (CLASS_W + MID_W + THR_W);

   // line classes
   localparam logic [CLASS_W-1:0] CLASS_NONE  = 2'd0;
   localparam logic [CLASS_W-1:0] CLASS_LINE  = 2'd1;
   localparam logic [CLASS_W-1:0] CLASS_CROSS = 2'd2;

   localparam logic [CSR_W-1:0] CROSS_SCALE_RESET = 8'd48;

   // expected width arithmetic: width = (WIDTH_NUM - ROW_COEF*row) / WIDTH_DEN
   localparam int WIDTH_NUM  = 129600;
   localparam int ROW_COEF   = 87;
   localparam int WIDTH_DEN  = 720;
   localparam int CROSS_COEF = 11520;
   localparam int CROSS_BIAS = 10;
   localparam int SIDE_WIDTH = 100;
   localparam int SIDE_COEF  = 16;
   localparam int RUN_MAX    = 4095;
   localparam int NUM_SHIFT  = 7;

   typedef enum logic [2:0] {
      ST_RUN,
      ST_CLOSE,
      ST_MUL,
      ST_DIV_INIT,
      ST_DIV,
      ST_LOAD
   } state_type;

   typedef struct packed {
      logic accept;
      logic close;
      logic mul;
      logic div_start;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic closing;
      logic last;
      logic row_last;
      logic need_div;
      logic rsp_blocked;
   } status_type;

endpackage

>>> rtl/sdrc_ctrl.sv
// Controller of the classifier: sequences pixel beats, run close, threshold divide, result load.
// Depends on sdrc_pkg.
module sdrc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  sdrc_pkg::status_type status,
   input  logic                 div_busy,
   output sdrc_pkg::cmd_type    cmd
);
   import sdrc_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_RUN: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               if (status.closing) begin
                  state_in = ST_CLOSE;
               end else if (status.last) begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_CLOSE: begin
            cmd.close = 1'b1;
            state_in  = status.row_last ? ST_MUL : ST_RUN;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = status.need_div ? ST_DIV_INIT : ST_LOAD;
         end
         ST_DIV_INIT: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            if (!div_busy) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            // hold until the result register is free
            if (!status.rsp_blocked) begin
               cmd.load = 1'b1;
               state_in = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

endmodule

>>> rtl/sdrc_div.sv
// Restoring divider for the row-end threshold: one quotient bit per cycle, saturating.
// Depends on sdrc_pkg.
module sdrc_div #(
   parameter int COL_W = 11
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   input  logic [sdrc_pkg::SUM_W+COL_W:0]          prod_a,
   input  logic [sdrc_pkg::SUM_W+COL_W-1:0]        prod_b,
   input  logic [2*COL_W:0]                        den,
   output logic                                    busy,
   output logic [sdrc_pkg::Q_W-1:0]                quot
);
   import sdrc_pkg::*;

   localparam int N_W   = SUM_W + COL_W + 2 + NUM_SHIFT;
   localparam int D_W   = 2 * COL_W + 1;
   localparam int X_W   = (N_W > D_W + Q_W) ? N_W : D_W + Q_W;
   localparam int CNT_W = $clog2(Q_W);

   logic [X_W-1:0]   rem_ff, rem_in;
   logic [X_W-1:0]   dvs_ff, dvs_in;
   logic [Q_W-1:0]   q_ff, q_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             sat_ff, sat_in;
   logic [X_W-1:0]   num;
   logic [X_W:0]     trial;

   // load on start, then one trial subtraction per cycle
   always_comb begin
      num     = (X_W'(prod_a) + X_W'(prod_b)) << NUM_SHIFT;
      trial   = {1'b0, rem_ff} - {1'b0, dvs_ff};
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      sat_in  = sat_ff;
      if (start) begin
         rem_in  = num;
         dvs_in  = X_W'(den) << (Q_W - 1);
         q_in    = '0;
         cnt_in  = CNT_W'(Q_W - 1);
         busy_in = 1'b1;
         sat_in  = num >= (X_W'(den) << Q_W);
      end else if (busy_ff) begin
         if (!trial[X_W]) begin
            rem_in = trial[X_W-1:0];
         end
         q_in   = {q_ff[Q_W-2:0], ~trial[X_W]};
         dvs_in = dvs_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   // datapath registers need no reset
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
      sat_ff <= sat_in;
   end

   assign busy = busy_ff;
   assign quot = sat_ff ? '1 : q_ff;

endmodule

>>> rtl/sdrc_datapath.sv
// Datapath of the classifier: run tracking, sums, run-close tests, products and result register.
// Depends on sdrc_pkg; its products feed sdrc_div.
module sdrc_datapath #(
   parameter int COL_W    = 11,
   parameter int LAST_COL = 2047
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  sdrc_pkg::cmd_type                      cmd,
   output sdrc_pkg::status_type                   status,
   input  logic [sdrc_pkg::PIX_W-1:0]             pixel,
   input  logic [sdrc_pkg::ROW_W-1:0]             row_index,
   input  logic                                   side_mode,
   input  logic [sdrc_pkg::THR_W-1:0]             threshold_in,
   input  logic                                   row_end,
   input  logic                                   csr_valid,
   input  logic [sdrc_pkg::CSR_W-1:0]             csr_data,
   input  logic                                   rsp_tready,
   input  logic [sdrc_pkg::Q_W-1:0]               div_quot,
   output logic [sdrc_pkg::SUM_W+COL_W:0]         prod_a,
   output logic [sdrc_pkg::SUM_W+COL_W-1:0]       prod_b,
   output logic [2*COL_W:0]                       den,
   output logic                                   rsp_valid,
   output logic [sdrc_pkg::CLASS_W-1:0]           rsp_class,
   output logic signed [sdrc_pkg::MID_W-1:0]      rsp_mid,
   output logic [sdrc_pkg::THR_W-1:0]             rsp_thr
);
   import sdrc_pkg::*;

   localparam int PW = (COL_W + 16 > 28) ? COL_W + 16 : 28;

   // row state
   logic [THR_W-1:0]        row_thr_ff, row_thr_in;
   logic                    in_run_ff, in_run_in;
   logic [COL_W-1:0]        run_start_ff, run_start_in;
   logic [RUN_W-1:0]        run_width_ff, run_width_in;
   logic [COL_W-1:0]        dark_total_ff, dark_total_in;
   logic [SUM_W-1:0]        dark_sum_ff, dark_sum_in;
   logic [SUM_W-1:0]        light_sum_ff, light_sum_in;
   logic [COL_W-1:0]        column_ff, column_in;
   logic [CLASS_W-1:0]      class_ff, class_in;
   logic signed [MID_W-1:0] mid_ff, mid_in;
   logic [CSR_W-1:0]        cross_scale_ff, cross_scale_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   // values captured with the pixel beat for the close step
   logic [ROW_TERM_W-1:0]   row_term_ff, row_term_in;
   logic                    side_ff, side_in;
   logic                    last_ff, last_in;
   // products and result payload
   logic [SUM_W+COL_W:0]    prod_a_ff, prod_a_in;
   logic [SUM_W+COL_W-1:0]  prod_b_ff, prod_b_in;
   logic [2*COL_W:0]        den_ff, den_in;
   logic [CLASS_W-1:0]      rsp_class_ff, rsp_class_in;
   logic signed [MID_W-1:0] rsp_mid_ff, rsp_mid_in;
   logic [THR_W-1:0]        rsp_thr_ff, rsp_thr_in;

   // combinational helpers
   logic                    col_zero;
   logic [THR_W-1:0]        thr;
   logic [THR_W-1:0]        scaled;
   logic                    is_dark;
   logic                    is_light;
   logic                    is_last;
   logic signed [PW-1:0]    excess_s;
   logic signed [PW-1:0]    exp_term_s;
   logic signed [PW-1:0]    cs_s;
   logic [PW-1:0]           wide_sum;
   logic                    wide;
   logic                    crossing;
   logic [MID_W-1:0]        run_mid;
   logic [COL_W:0]          pixels;
   logic [COL_W:0]          ln;
   logic                    need_div;
   logic [THR_W-1:0]        thr_out;

   // classify the incoming pixel against the row threshold
   always_comb begin
      col_zero = column_ff == '0;
      thr      = col_zero ? threshold_in : row_thr_ff;
      scaled   = {pixel, {(THR_W - PIX_W){1'b0}}};
      is_dark  = scaled < thr;
      is_light = scaled > thr;
      is_last  = row_end || (column_ff >= COL_W'(LAST_COL));
   end

   // wide and cross tests of the run being closed
   always_comb begin
      excess_s   = $signed(PW'(dark_total_ff)) - PW'(CROSS_BIAS);
      exp_term_s = PW'(WIDTH_NUM) - $signed(PW'(row_term_ff));
      cs_s       = $signed(PW'(cross_scale_ff));
      wide_sum   = PW'(run_width_ff) * PW'(WIDTH_DEN) + PW'(row_term_ff);
      if (side_ff) begin
         wide     = run_width_ff > RUN_W'(SIDE_WIDTH);
         crossing = (PW'(SIDE_COEF) * excess_s) > (PW'(SIDE_WIDTH) * cs_s);
      end else begin
         wide     = wide_sum > PW'(WIDTH_NUM);
         crossing = (PW'(CROSS_COEF) * excess_s) > (exp_term_s * cs_s);
      end
      run_mid = MID_W'(run_start_ff) + MID_W'(run_width_ff >> 1);
   end

   // dark and light pixel counts for the threshold update
   always_comb begin
      pixels   = (COL_W + 1)'(column_ff) + 1'b1;
      ln       = pixels - (COL_W + 1)'(dark_total_ff);
      need_div = (class_ff == CLASS_LINE) && (dark_total_ff != '0)
                 && (pixels > (COL_W + 1)'(dark_total_ff));
      thr_out  = need_div ? div_quot : row_thr_ff;
   end

   always_comb begin
      status.closing     = (is_light || is_last) && (in_run_ff || is_dark);
      status.last        = is_last;
      status.row_last    = last_ff;
      status.need_div    = need_div;
      status.rsp_blocked = rsp_valid_ff && !rsp_tready;
   end

   // next values of all registers
   always_comb begin
      row_thr_in     = row_thr_ff;
      in_run_in      = in_run_ff;
      run_start_in   = run_start_ff;
      run_width_in   = run_width_ff;
      dark_total_in  = dark_total_ff;
      dark_sum_in    = dark_sum_ff;
      light_sum_in   = light_sum_ff;
      column_in      = column_ff;
      class_in       = class_ff;
      mid_in         = mid_ff;
      cross_scale_in = cross_scale_ff;
      row_term_in    = row_term_ff;
      side_in        = side_ff;
      last_in        = last_ff;
      prod_a_in      = prod_a_ff;
      prod_b_in      = prod_b_ff;
      den_in         = den_ff;
      rsp_class_in   = rsp_class_ff;
      rsp_mid_in     = rsp_mid_ff;
      rsp_thr_in     = rsp_thr_ff;
      rsp_valid_in   = rsp_tready ? 1'b0 : rsp_valid_ff;

      // take the register write
      if (csr_valid) begin
         cross_scale_in = csr_data;
      end

      // advance over one pixel beat
      if (cmd.accept) begin
         if (col_zero) begin
            row_thr_in = threshold_in;
         end
         if (is_dark) begin
            dark_sum_in = dark_sum_ff + SUM_W'(pixel);
            if (!in_run_ff) begin
               run_start_in = column_ff;
               run_width_in = RUN_W'(1);
               in_run_in    = 1'b1;
            end else begin
               if (run_width_ff != RUN_W'(RUN_MAX)) begin
                  run_width_in = run_width_ff + 1'b1;
               end
               dark_total_in = dark_total_ff + 1'b1;
            end
         end
         if (is_light || is_last) begin
            light_sum_in = light_sum_ff + SUM_W'(pixel);
         end
         if (!is_last) begin
            column_in = column_ff + 1'b1;
         end
         row_term_in = ROW_TERM_W'(row_index) * ROW_TERM_W'(ROW_COEF);
         side_in     = side_mode;
         last_in     = is_last;
      end

      // close the run and record what it found
      if (cmd.close) begin
         in_run_in = 1'b0;
         if (wide) begin
            class_in = CLASS_LINE;
            mid_in   = $signed(run_mid);
         end
         if (crossing) begin
            class_in = CLASS_CROSS;
         end
      end

      // register the numerator and denominator products
      if (cmd.mul) begin
         prod_a_in = (SUM_W + COL_W + 1)'(dark_sum_ff) * (SUM_W + COL_W + 1)'(ln);
         prod_b_in = (SUM_W + COL_W)'(light_sum_ff) * (SUM_W + COL_W)'(dark_total_ff);
         den_in    = (2 * COL_W + 1)'(dark_total_ff) * (2 * COL_W + 1)'(ln);
      end

      // load the result and clear the row
      if (cmd.load) begin
         rsp_valid_in  = 1'b1;
         rsp_class_in  = class_ff;
         rsp_mid_in    = mid_ff;
         rsp_thr_in    = thr_out;
         if (class_ff == CLASS_LINE) begin
            row_thr_in = thr_out;
         end
         in_run_in     = 1'b0;
         run_start_in  = '0;
         run_width_in  = '0;
         dark_total_in = '0;
         dark_sum_in   = '0;
         light_sum_in  = '0;
         column_in     = '0;
         class_in      = CLASS_NONE;
         mid_in        = '1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_thr_ff     <= '0;
         in_run_ff      <= 1'b0;
         run_start_ff   <= '0;
         run_width_ff   <= '0;
         dark_total_ff  <= '0;
         dark_sum_ff    <= '0;
         light_sum_ff   <= '0;
         column_ff      <= '0;
         class_ff       <= CLASS_NONE;
         mid_ff         <= '1;
         cross_scale_ff <= CROSS_SCALE_RESET;
         rsp_valid_ff   <= 1'b0;
         last_ff        <= 1'b0;
      end else begin
         row_thr_ff     <= row_thr_in;
         in_run_ff      <= in_run_in;
         run_start_ff   <= run_start_in;
         run_width_ff   <= run_width_in;
         dark_total_ff  <= dark_total_in;
         dark_sum_ff    <= dark_sum_in;
         light_sum_ff   <= light_sum_in;
         column_ff      <= column_in;
         class_ff       <= class_in;
         mid_ff         <= mid_in;
         cross_scale_ff <= cross_scale_in;
         rsp_valid_ff   <= rsp_valid_in;
         last_ff        <= last_in;
      end
   end

   // payload registers need no reset
   always_ff @(posedge clock) begin
      row_term_ff  <= row_term_in;
      side_ff      <= side_in;
      prod_a_ff    <= prod_a_in;
      prod_b_ff    <= prod_b_in;
      den_ff       <= den_in;
      rsp_class_ff <= rsp_class_in;
      rsp_mid_ff   <= rsp_mid_in;
      rsp_thr_ff   <= rsp_thr_in;
   end

   assign prod_a    = prod_a_ff;
   assign prod_b    = prod_b_ff;
   assign den       = den_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_class = rsp_class_ff;
   assign rsp_mid   = rsp_mid_ff;
   assign rsp_thr   = rsp_thr_ff;

endmodule

>>> rtl/scanline_dark_run_classifier_top.sv
// Throughput: one pixel beat per cycle while in the run state; a pixel that closes a dark run adds a close step.
// Row end: the close step if the last pixel closes a run, then the products, then the 16-step restoring
// divider when the threshold is updated, then the result load, which waits while an earlier result is unread.
// The next row's pixels are taken while an earlier result still waits on the rsp side.
// Reset is synchronous, active high: cross_scale returns to 48, row state clears, no result pends.
// Depends on sdrc_pkg, sdrc_ctrl, sdrc_div, sdrc_datapath and assert_macros.svh.
`include "assert_macros.svh"

module scanline_dark_run_classifier_top #(
   parameter int MAX_COLUMNS = 2048
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // pixel[7:0], row_index[18:8], threshold_in[34:19], zero pad [39:35]
   input  logic [sdrc_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              req_tlast,  // row_end
   input  logic [sdrc_pkg::REQ_USER_W-1:0]   req_tuser,  // side_mode[0]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // line_class[1:0], line_mid[13:2], threshold_out[29:14], zero pad [31:30]
   output logic [sdrc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [sdrc_pkg::CSR_W-1:0]        csr_data
);
   import sdrc_pkg::*;

   localparam int COL_W = $clog2(MAX_COLUMNS);

   cmd_type                 cmd;
   status_type              status;
   logic                    div_busy;
   logic [Q_W-1:0]          div_quot;
   logic [SUM_W+COL_W:0]    prod_a;
   logic [SUM_W+COL_W-1:0]  prod_b;
   logic [2*COL_W:0]        den;
   logic [CLASS_W-1:0]      rsp_line_class;
   logic signed [MID_W-1:0] rsp_line_mid;
   logic [THR_W-1:0]        rsp_threshold_out;
   logic                    rsp_no_line;

   assign csr_ready = 1'b1;

   sdrc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .div_busy   (div_busy),
      .cmd        (cmd)
   );

   sdrc_datapath #(
      .COL_W    (COL_W),
      .LAST_COL (MAX_COLUMNS - 1)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .pixel        (req_tdata[7:0]),
      .row_index    (req_tdata[18:8]),
      .side_mode    (req_tuser[0]),
      .threshold_in (req_tdata[34:19]),
      .row_end      (req_tlast),
      .csr_valid    (csr_valid),
      .csr_data     (csr_data),
      .rsp_tready   (rsp_tready),
      .div_quot     (div_quot),
      .prod_a       (prod_a),
      .prod_b       (prod_b),
      .den          (den),
      .rsp_valid    (rsp_tvalid),
      .rsp_class    (rsp_line_class),
      .rsp_mid      (rsp_line_mid),
      .rsp_thr      (rsp_threshold_out)
   );

   sdrc_div #(
      .COL_W (COL_W)
   ) u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.div_start),
      .prod_a (prod_a),
      .prod_b (prod_b),
      .den    (den),
      .busy   (div_busy),
      .quot   (div_quot)
   );

   // pack the result beat
   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, rsp_threshold_out, rsp_line_mid, rsp_line_class};

   assign rsp_no_line = rsp_tvalid && (rsp_line_class == CLASS_NONE);

   // no pixel is taken while the threshold divide runs
   `SDRC_ASSERT_IMPLY(a_no_take_while_dividing, clock, reset, div_busy, !req_tready)
   // a row with no line never reports a midpoint
   `SDRC_ASSERT_IMPLY(a_none_has_no_mid, clock, reset, rsp_no_line, rsp_line_mid == '1)
   // a result load leaves the result valid and the input open
   `SDRC_ASSERT_NEXT(a_load_reopens, clock, reset, cmd.load, req_tready && rsp_tvalid)

endmodule

>>> sim/sdrc_row_checker.sv
`timescale 1ns / 1ps
// Row verdict checker for the scanline dark run classifier: follows pixel, CSR and result beats,
// predicts the verdict of each row and compares every result beat with the oldest prediction.
// Depends on sdrc_pkg for field widths and line class codes.
module sdrc_row_checker #(
   parameter int MAX_COLUMNS = 2048
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [sdrc_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              req_tlast,
   input  logic [sdrc_pkg::REQ_USER_W-1:0]   req_tuser,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [sdrc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [sdrc_pkg::CSR_W-1:0]        csr_data,
   output int                                mismatch_count,
   output int                                pending_results
);
   import sdrc_pkg::*;

   // expected width is (FULL_SPAN - ROW_SLOPE*row) / SPAN_DIV, or SIDE_LINE_WIDTH in side mode
   localparam longint FULL_SPAN       = 129600;
   localparam longint ROW_SLOPE       = 87;
   localparam longint SPAN_DIV        = 720;
   localparam longint CROSS_MUL       = 11520;
   localparam longint CROSS_SLACK     = 10;
   localparam longint SIDE_LINE_WIDTH = 100;
   localparam longint SIDE_MUL        = 16;
   localparam int     RUN_CAP         = 4095;
   localparam int     REPORT_LIMIT    = 10;

   typedef struct packed {
      logic [CLASS_W-1:0] line_class;
      logic [MID_W-1:0]   line_mid;
      logic [THR_W-1:0]   threshold;
   } row_verdict_t;

   row_verdict_t row_verdicts[$];

   // predicted block state
   logic [CSR_W-1:0]   cross_scale;
   logic [THR_W-1:0]   row_thr;
   logic               in_run;
   int unsigned        run_start;
   int unsigned        run_width;
   int unsigned        dark_count;
   int unsigned        dark_sum;
   int unsigned        light_sum;
   int unsigned        column;
   logic [CLASS_W-1:0] found_class;
   logic [MID_W-1:0]   found_mid;
   int                 rows_checked;

   function automatic void clear_row_state();
      in_run      = 1'b0;
      run_start   = 0;
      run_width   = 0;
      dark_count  = 0;
      dark_sum    = 0;
      light_sum   = 0;
      column      = 0;
      found_class = CLASS_NONE;
      found_mid   = '1;
   endfunction

   // Close the open dark run: wide runs mark a line, a large dark total marks a crossing
   function automatic void close_dark_run(int unsigned row, logic side);
      longint excess;
      logic   wide;
      logic   crossing;
      excess = longint'(dark_count) - CROSS_SLACK;
      if (side) begin
         wide     = longint'(run_width) > SIDE_LINE_WIDTH;
         crossing = SIDE_MUL * excess > SIDE_LINE_WIDTH * longint'(cross_scale);
      end else begin
         wide     = SPAN_DIV * longint'(run_width) + ROW_SLOPE * longint'(row) > FULL_SPAN;
         crossing = CROSS_MUL * excess >
                    (FULL_SPAN - ROW_SLOPE * longint'(row)) * longint'(cross_scale);
      end
      in_run = 1'b0;
      if (wide) begin
         found_class = CLASS_LINE;
         found_mid   = run_start + run_width / 2;
      end
      if (crossing)
         found_class = CLASS_CROSS;
   endfunction

   // Mean of dark and light averages in 8.8, saturated; unchanged with no non-first dark pixel
   function automatic logic [THR_W-1:0] updated_threshold();
      longint unsigned pixels;
      longint unsigned dn;
      longint unsigned ln;
      longint unsigned ds;
      longint unsigned ls;
      longint unsigned q;
      pixels = column + 1;
      dn     = dark_count;
      ds     = dark_sum;
      ls     = light_sum;
      if (dn == 0 || pixels <= dn)
         return row_thr;
      ln = pixels - dn;
      q  = ((ds * ln + ls * dn) * 128) / (dn * ln);
      return (q > 65535) ? 16'hFFFF : q[15:0];
   endfunction

   // Advance the row state by one pixel; queue a verdict when the row ends
   function automatic void track_pixel(logic [PIX_W-1:0] pix, logic [ROW_W-1:0] row,
                                       logic side, logic [THR_W-1:0] thr_in, logic row_end);
      logic         last;
      int unsigned  scaled;
      row_verdict_t verdict;
      last   = row_end || column >= MAX_COLUMNS - 1;
      scaled = int'(pix) * 256;
      if (column == 0)
         row_thr = thr_in;
      if (scaled < row_thr) begin
         dark_sum += pix;
         if (!in_run) begin
            run_start = column;
            run_width = 1;
            in_run    = 1'b1;
         end else begin
            if (run_width < RUN_CAP)
               run_width++;
            dark_count++;
         end
      end
      if (scaled > row_thr || last) begin
         light_sum += pix;
         if (in_run)
            close_dark_run(row, side);
      end
      if (!last) begin
         column++;
         return;
      end
      verdict.line_class = found_class;
      verdict.line_mid   = found_mid;
      verdict.threshold  = (found_class == CLASS_LINE) ? updated_threshold() : row_thr;
      if (found_class == CLASS_LINE)
         row_thr = verdict.threshold;
      row_verdicts.push_back(verdict);
      clear_row_state();
   endfunction

   // Watch all three channels at each rising edge
   always @(posedge clock) begin : watch
      row_verdict_t want;
      row_verdict_t got;
      if (reset) begin
         cross_scale  = CROSS_SCALE_RESET;
         row_thr      = '0;
         rows_checked = 0;
         clear_row_state();
         row_verdicts.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.line_class = rsp_tdata[1:0];
            got.line_mid   = rsp_tdata[13:2];
            got.threshold  = rsp_tdata[29:14];
            if (row_verdicts.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("%0t: result beat with no row pending: class %0d mid %0d thr %h",
                           $realtime, got.line_class, $signed(got.line_mid), got.threshold);
            end else begin
               want = row_verdicts.pop_front();
               if (got.line_class !== want.line_class || got.line_mid !== want.line_mid ||
                   got.threshold !== want.threshold) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display({"%0t: row %0d verdict: class exp %0d got %0d, ",
                               "mid exp %0d got %0d, thr exp %h got %h"},
                              $realtime, rows_checked, want.line_class, got.line_class,
                              $signed(want.line_mid), $signed(got.line_mid),
                              want.threshold, got.threshold);
               end
               rows_checked++;
            end
         end
         if (csr_valid && csr_ready)
            cross_scale = csr_data;
         if (req_tvalid && req_tready)
            track_pixel(req_tdata[7:0], req_tdata[18:8], req_tuser[0], req_tdata[34:19],
                        req_tlast);
      end
      pending_results = row_verdicts.size();
   end

endmodule

>>> sim/scanline_dark_run_classifier_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for the scanline dark run classifier: drives pixel rows and CSR writes under
// varying backpressure and gives the verdict. Depends on sdrc_pkg, the block and sdrc_row_checker.
module scanline_dark_run_classifier_top_tb;
   import sdrc_pkg::*;

   localparam int MAX_COLUMNS  = 2048;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_CYCLES  = 400;
   localparam int PHASE_ITEMS  = 180;
   localparam int PHASE_ROWS   = 3;

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata;
   logic                    req_tlast;
   logic [REQ_USER_W-1:0]   req_tuser;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CSR_W-1:0]        csr_data;

   int   mismatch_count;
   int   pending_results;
   int   send_idle_pct;
   int   take_idle_pct;
   logic hold_request;
   int   items_sent;
   int   quiet_cycles;

   scanline_dark_run_classifier_top #(
      .MAX_COLUMNS (MAX_COLUMNS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   sdrc_row_checker #(
      .MAX_COLUMNS (MAX_COLUMNS)
   ) row_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tlast       (req_tlast),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Result side: random stalls, or one long hold-off when asked for
   initial begin : result_sink
      int held;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_tready <= 1'b0;
            for (held = 0; held < HOLD_CYCLES; held++)
               @(negedge clock);
            hold_request = 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= take_idle_pct);
         end
      end
   end

   // End the run when no beat moves on any channel for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // Offer one pixel beat and hold it until accepted
   task automatic push_pixel(input logic [PIX_W-1:0] pix, input logic [ROW_W-1:0] row,
                             input logic side, input logic [THR_W-1:0] thr,
                             input logic row_end);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, thr, row, pix};
      req_tlast  <= row_end;
      req_tuser  <= side;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   // Drop the pixel channel, then write cross_scale once the block has gone idle
   task automatic write_cross_scale(input logic [CSR_W-1:0] value);
      req_tvalid <= 1'b0;
      while (pending_results != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Fixed pixel row; the threshold field only matters on the first pixel
   task automatic send_pixels(input logic [ROW_W-1:0] row, input logic side,
                              input logic [THR_W-1:0] thr, input logic [PIX_W-1:0] pixels[$]);
      int col;
      for (col = 0; col < pixels.size(); col++)
         push_pixel(pixels[col], row, side, (col == 0) ? thr : 16'($urandom),
                    col == pixels.size() - 1);
   endtask

   function automatic logic [PIX_W-1:0] pick_pixel(logic [THR_W-1:0] thr, logic dark);
      if (dark) begin
         if (thr == 0)
            return 8'd0;
         return 8'($urandom_range((thr - 1) >> 8, 0));
      end
      if (thr[15:8] == 8'hFF)
         return 8'hFF;
      return 8'($urandom_range(255, thr[15:8] + 1));
   endfunction

   // Row of alternating dark and light stretches; without row_end it runs to the column limit
   task automatic send_row(input int len, input logic [ROW_W-1:0] row, input logic side,
                           input logic [THR_W-1:0] thr, input logic use_tlast);
      logic             dark;
      int               seg_left;
      int               col;
      logic [PIX_W-1:0] pix;
      dark     = 1'($urandom_range(1));
      seg_left = 0;
      for (col = 0; col < len; col++) begin
         if (seg_left == 0) begin
            dark     = ~dark;
            seg_left = dark ? $urandom_range(len, 1) : $urandom_range(6, 1);
         end
         seg_left--;
         pix = ($urandom_range(15) == 0) ? thr[15:8] : pick_pixel(thr, dark);
         push_pixel(pix, row, side, (col == 0) ? thr : 16'($urandom),
                    use_tlast && col == len - 1);
      end
   endtask

   // Mostly short rows on low image rows, where narrow runs already count as lines
   task automatic send_random_row();
      int               len;
      logic [ROW_W-1:0] row;
      logic             side;
      logic [THR_W-1:0] thr;
      case ($urandom_range(19))
         0: len = $urandom_range(220, 101);
         1, 2, 3, 4, 5: len = $urandom_range(100, 25);
         default: len = $urandom_range(24, 1);
      endcase
      side = ($urandom_range(3) == 0);
      if (side && $urandom_range(1))
         len = $urandom_range(180, 90);
      row = 11'($urandom_range(1) ? $urandom_range(2047, 1400) : $urandom_range(2047, 0));
      thr = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(200 * 256, 30 * 256));
      send_row(len, row, side, thr, 1'b1);
   endtask

   task automatic send_row_batch();
      int first_item;
      int rows;
      first_item = items_sent;
      rows       = 0;
      while (items_sent - first_item < PHASE_ITEMS || rows < PHASE_ROWS) begin
         send_random_row();
         rows++;
      end
   endtask

   initial begin : stimulus
      int               phase;
      logic [CSR_W-1:0] scale_plan[6];
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tlast     = 1'b0;
      req_tuser     = '0;
      csr_valid     = 1'b0;
      csr_data      = '0;
      send_idle_pct = 0;
      take_idle_pct = 0;
      hold_request  = 1'b0;
      items_sent    = 0;
      quiet_cycles  = 0;
      scale_plan    = '{8'd255, 8'd0, 8'($urandom), 8'd1, 8'($urandom), CROSS_SCALE_RESET};
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed rows at the reset cross_scale
      // all dark on the top row, last pixel dark
      send_pixels(11'd0, 1'b0, 16'hFFFF, {8'd0, 8'd255, 8'd0});
      // zero threshold: nothing is dark
      send_pixels(11'd2047, 1'b1, 16'h0000, {8'd255, 8'd0});
      // single dark pixel line, no non-first dark pixel
      send_pixels(11'd2047, 1'b0, 16'h8000, {8'd0});
      // two runs, the second closed by row end
      send_pixels(11'd2047, 1'b0, 16'h8000, {8'd10, 8'd10, 8'd200, 8'd200, 8'd10});
      // pixels equal to the threshold
      send_pixels(11'd100, 1'b0, 16'h6400, {8'd100, 8'd50, 8'd100, 8'd150});
      // new threshold saturates
      send_pixels(11'd1480, 1'b0, 16'hFFFF, {8'd254, 8'd254, 8'd254});
      // ordinary threshold update
      send_pixels(11'd1480, 1'b0, 16'h8000, {8'd20, 8'd30, 8'd200, 8'd220});
      send_pixels(11'd0, 1'b1, 16'h8000, {8'd0, 8'd255});

      // random rows: slow receiver, then slow sender, then neither
      for (phase = 0; phase < 6; phase++) begin
         write_cross_scale(scale_plan[phase]);
         send_idle_pct = (phase < 2) ? 22 : (phase < 4) ? 73 : 0;
         take_idle_pct = (phase < 2) ? 73 : (phase < 4) ? 22 : 0;
         if (phase == 4)
            hold_request = 1'b1;
         send_row_batch();
      end
      req_tvalid <= 1'b0;

      while (pending_results != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && pending_results == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
